// ----- rtl/core/u16to8_pkg.sv -----
// Shared types and constants for the UTF-16/UTF-32 to UTF-8 transcoder.
package u16to8_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_UNPAIRED_HI = 2'd1;
   localparam logic [1:0] ERR_LONE_LO     = 2'd2;
   localparam logic [1:0] ERR_BAD_SCALAR  = 2'd3;

   localparam logic [31:0] SURR_FIRST   = 32'h0000_D800;
   localparam logic [31:0] HIGH_LAST    = 32'h0000_DBFF;
   localparam logic [31:0] LOW_FIRST    = 32'h0000_DC00;
   localparam logic [31:0] SURR_LAST    = 32'h0000_DFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h01_0000;
   localparam logic [20:0] ONE_BYTE_MAX = 21'h00_007F;
   localparam logic [20:0] TWO_BYTE_MAX = 21'h00_07FF;
   localparam logic [20:0] BMP_MAX      = 21'h00_FFFF;
   localparam logic [31:0] SCALAR_MAX   = 32'h0010_FFFF;
   localparam logic [7:0]  LEAD2        = 8'hC0;
   localparam logic [7:0]  LEAD3        = 8'hE0;
   localparam logic [7:0]  LEAD4        = 8'hF0;
   localparam logic [7:0]  CONT         = 8'h80;

   typedef struct packed {
      logic [31:0] code_unit;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_last;
      logic       error;
      logic [1:0] error_kind;
   } rsp_type;

   // One classified unit: up to four bytes, first byte in slot 0.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      count_m1;
      logic            str_last;
      logic            error;
      logic [1:0]      error_kind;
   } job_type;

endpackage

// ----- rtl/core/u16to8_front.sv -----
// Front end: surrogate pairing, validation and UTF-8 byte formation per unit.
module u16to8_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic                 in_accept,
   input  u16to8_pkg::req_type  in_data,
   output logic                 job_push,
   output u16to8_pkg::job_type  job_data
);

   logic        mode32_ff,  mode32_in;
   logic [9:0]  held_ff,    held_in;
   logic        pending_ff, pending_in;
   logic        discard_ff, discard_in;

   logic [31:0] unit;
   logic [31:0] unit16;
   logic        is_high;
   logic        is_low;
   logic        is_surr32;
   logic [20:0] pair_cp;
   logic [20:0] enc_cp;
   logic        do_enc;
   logic        do_err;
   logic [1:0]  err_kind;

   function automatic u16to8_pkg::job_type encode(input logic [20:0] cp, input logic last);
      u16to8_pkg::job_type j;
      j            = '0;
      j.str_last   = last;
      j.error      = 1'b0;
      j.error_kind = u16to8_pkg::ERR_NONE;
      if (cp <= u16to8_pkg::ONE_BYTE_MAX) begin
         j.bytes[0] = cp[7:0];
         j.count_m1 = 2'd0;
      end else if (cp <= u16to8_pkg::TWO_BYTE_MAX) begin
         j.bytes[0] = u16to8_pkg::LEAD2 | {3'b000, cp[10:6]};
         j.bytes[1] = u16to8_pkg::CONT  | {2'b00, cp[5:0]};
         j.count_m1 = 2'd1;
      end else if (cp <= u16to8_pkg::BMP_MAX) begin
         j.bytes[0] = u16to8_pkg::LEAD3 | {4'b0000, cp[15:12]};
         j.bytes[1] = u16to8_pkg::CONT  | {2'b00, cp[11:6]};
         j.bytes[2] = u16to8_pkg::CONT  | {2'b00, cp[5:0]};
         j.count_m1 = 2'd2;
      end else begin
         j.bytes[0] = u16to8_pkg::LEAD4 | {5'b00000, cp[20:18]};
         j.bytes[1] = u16to8_pkg::CONT  | {2'b00, cp[17:12]};
         j.bytes[2] = u16to8_pkg::CONT  | {2'b00, cp[11:6]};
         j.bytes[3] = u16to8_pkg::CONT  | {2'b00, cp[5:0]};
         j.count_m1 = 2'd3;
      end
      return j;
   endfunction

   assign unit      = in_data.code_unit;
   assign unit16    = {16'h0000, unit[15:0]};
   assign is_high   = (unit16 >= u16to8_pkg::SURR_FIRST) && (unit16 <= u16to8_pkg::HIGH_LAST);
   assign is_low    = (unit16 >= u16to8_pkg::LOW_FIRST) && (unit16 <= u16to8_pkg::SURR_LAST);
   assign is_surr32 = (unit >= u16to8_pkg::SURR_FIRST) && (unit <= u16to8_pkg::SURR_LAST);
   assign pair_cp   = u16to8_pkg::SUPP_BASE + {1'b0, held_ff, unit[9:0]};

   always_comb begin
      do_enc     = 1'b0;
      do_err     = 1'b0;
      err_kind   = u16to8_pkg::ERR_NONE;
      enc_cp     = unit16[20:0];
      mode32_in  = mode32_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      discard_in = discard_ff;

      if (in_accept) begin
         if (discard_ff) begin
            // drop the rest of a rejected string
            if (in_data.last) discard_in = 1'b0;
         end else if (mode32_ff) begin
            if ((unit > u16to8_pkg::SCALAR_MAX) || is_surr32) begin
               do_err   = 1'b1;
               err_kind = u16to8_pkg::ERR_BAD_SCALAR;
            end else begin
               do_enc = 1'b1;
               enc_cp = unit[20:0];
            end
         end else if (pending_ff) begin
            if (is_low) begin
               do_enc     = 1'b1;
               enc_cp     = pair_cp;
               pending_in = 1'b0;
               held_in    = '0;
            end else begin
               do_err   = 1'b1;
               err_kind = u16to8_pkg::ERR_UNPAIRED_HI;
            end
         end else if (is_high) begin
            if (in_data.last) begin
               do_err   = 1'b1;
               err_kind = u16to8_pkg::ERR_UNPAIRED_HI;
            end else begin
               held_in    = unit[9:0];
               pending_in = 1'b1;
            end
         end else if (is_low) begin
            do_err   = 1'b1;
            err_kind = u16to8_pkg::ERR_LONE_LO;
         end else begin
            do_enc = 1'b1;
         end

         if (do_err) begin
            pending_in = 1'b0;
            held_in    = '0;
            discard_in = ~in_data.last;
         end
      end

      // a mode write starts a fresh string
      if (csr_we) begin
         mode32_in  = csr_wdata;
         held_in    = '0;
         pending_in = 1'b0;
         discard_in = 1'b0;
      end
   end

   always_comb begin
      if (do_err) begin
         job_data            = '0;
         job_data.str_last   = 1'b1;
         job_data.error      = 1'b1;
         job_data.error_kind = err_kind;
      end else begin
         job_data = encode(enc_cp, in_data.last);
      end
   end

   assign job_push = do_enc | do_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode32_ff  <= 1'b0;
         held_ff    <= '0;
         pending_ff <= 1'b0;
         discard_ff <= 1'b0;
      end else begin
         mode32_ff  <= mode32_in;
         held_ff    <= held_in;
         pending_ff <= pending_in;
         discard_ff <= discard_in;
      end
   end

endmodule

// ----- rtl/core/u16to8_fifo.sv -----
// Short queue of classified units between front end and byte serialiser.
module u16to8_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u16to8_pkg::job_type  push_data,
   input  logic                 pop,
   output u16to8_pkg::job_type  head,
   output logic                 empty,
   output logic                 full
);

   u16to8_pkg::job_type                  slot_ff [u16to8_pkg::QueueDepth];
   logic [u16to8_pkg::QueuePtrW-1:0]     wr_ff, wr_in;
   logic [u16to8_pkg::QueuePtrW-1:0]     rd_ff, rd_in;
   logic [u16to8_pkg::QueueCntW-1:0]     cnt_ff, cnt_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == u16to8_pkg::QueueCntW'(u16to8_pkg::QueueDepth));
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + u16to8_pkg::QueuePtrW'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + u16to8_pkg::QueuePtrW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + u16to8_pkg::QueueCntW'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - u16to8_pkg::QueueCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- rtl/core/u16to8_back.sv -----
// Back end: serialises queued units into single-byte result words.
module u16to8_back (
   input  logic                 clock,
   input  logic                 reset,
   input  u16to8_pkg::job_type  head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output u16to8_pkg::rsp_type  rsp_data
);

   logic                 valid_ff, valid_in;
   u16to8_pkg::rsp_type  word_ff,  word_in;
   logic [1:0]           idx_ff,   idx_in;
   logic                 load;
   logic                 take;
   logic                 last_byte;

   assign load      = ~valid_ff | rsp_pop;
   assign take      = load & ~q_empty;
   assign last_byte = (idx_ff == head.count_m1);
   assign q_pop     = take & last_byte;

   always_comb begin
      valid_in = load ? ~q_empty : valid_ff;
      idx_in   = idx_ff;
      if (take) idx_in = last_byte ? 2'd0 : idx_ff + 2'd1;
      word_in             = word_ff;
      if (take) begin
         word_in.out_byte    = head.bytes[idx_ff];
         word_in.run_last    = last_byte;
         word_in.string_last = last_byte & head.str_last;
         word_in.error       = head.error;
         word_in.error_kind  = head.error_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // hold the output word while the receiver stalls
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rsp_empty = ~valid_ff;
   assign rsp_data  = word_ff;

endmodule

// ----- rtl/core/utf16_to_utf8_transcoder_core.sv -----
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder.
//
// Input queue: write one wide code unit per word with req_push while req_full is
// low; req_data.last marks the final unit of a string. Result queue: while
// rsp_empty is low, rsp_data holds the oldest UTF-8 byte; rsp_pop takes it.
// Each code point yields one to four bytes; an invalid unit yields one error
// word with string_last set, and the rest of that string is dropped.
// csr_we/csr_wdata select UTF-32 (1) or UTF-16 (0) mode and start a fresh
// string; write only while no word is in flight.
// The first byte of a unit passes the unit queue and the output word register
// on its way to the result port. A unit can be taken every cycle while the
// four-entry unit queue has room; the byte serialiser drains one byte per
// cycle while the receiver pops, so a unit of n bytes stays at the queue head
// until all n are out. A high surrogate and dropped units produce no bytes.
// Reset (synchronous) selects UTF-16 mode, clears the pairing state and
// empties both queues. When the receiver stalls the output word holds, the
// unit queue fills, and req_full rises once four units are waiting.
module utf16_to_utf8_transcoder_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  u16to8_pkg::req_type  req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output u16to8_pkg::rsp_type  rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_wdata
);

   logic                 accept;
   logic                 job_push;
   u16to8_pkg::job_type  job_data;
   u16to8_pkg::job_type  head;
   logic                 q_empty;
   logic                 q_full;
   logic                 q_pop;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;

   u16to8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_accept (accept),
      .in_data   (req_data),
      .job_push  (job_push),
      .job_data  (job_data)
   );

   u16to8_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   u16to8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/utf16_to_utf8_transcoder_core_tb.sv -----
// Self-checking testbench for the UTF-16/UTF-32 to UTF-8 transcoder core.
module utf16_to_utf8_transcoder_core_tb;

   localparam int QuietLimit = 4000;
   localparam int SettleCycles = 10;
   localparam int PhaseUnits = 54;

   // Expected UTF-8 words, built from the accepted code units.
   class utf8_scoreboard;
      bit                   mode32;
      bit [9:0]             held_hi;
      bit                   hi_pending;
      bit                   dropping;
      u16to8_pkg::rsp_type  byte_q[$];
      int                   errors;

      function new();
         mode32 = 1'b0;
         held_hi = '0;
         hi_pending = 1'b0;
         dropping = 1'b0;
         errors = 0;
      endfunction

      function void set_mode(bit m);
         mode32 = m;
         held_hi = '0;
         hi_pending = 1'b0;
         dropping = 1'b0;
      endfunction

      function int pending();
         return byte_q.size();
      endfunction

      function void add_byte(logic [7:0] b, bit run_end, bit str_end, bit err,
                             logic [1:0] kind);
         u16to8_pkg::rsp_type w;
         w.out_byte = b;
         w.run_last = run_end;
         w.string_last = str_end;
         w.error = err;
         w.error_kind = kind;
         byte_q.insert(byte_q.size(), w);
      endfunction

      function void reject(logic [1:0] kind, bit last);
         hi_pending = 1'b0;
         held_hi = '0;
         dropping = !last;
         add_byte(8'h00, 1'b1, 1'b1, 1'b1, kind);
      endfunction

      function void emit_cp(logic [20:0] cp, bit last);
         logic [7:0] b[4];
         int n;
         if (cp <= u16to8_pkg::ONE_BYTE_MAX) begin
            b[0] = {1'b0, cp[6:0]};
            n = 1;
         end else if (cp <= u16to8_pkg::TWO_BYTE_MAX) begin
            b[0] = u16to8_pkg::LEAD2 | {3'b0, cp[10:6]};
            b[1] = u16to8_pkg::CONT | {2'b0, cp[5:0]};
            n = 2;
         end else if (cp <= u16to8_pkg::BMP_MAX) begin
            b[0] = u16to8_pkg::LEAD3 | {4'b0, cp[15:12]};
            b[1] = u16to8_pkg::CONT | {2'b0, cp[11:6]};
            b[2] = u16to8_pkg::CONT | {2'b0, cp[5:0]};
            n = 3;
         end else begin
            b[0] = u16to8_pkg::LEAD4 | {5'b0, cp[20:18]};
            b[1] = u16to8_pkg::CONT | {2'b0, cp[17:12]};
            b[2] = u16to8_pkg::CONT | {2'b0, cp[11:6]};
            b[3] = u16to8_pkg::CONT | {2'b0, cp[5:0]};
            n = 4;
         end
         for (int i = 0; i < n; i++)
            add_byte(b[i], i == n - 1, (i == n - 1) && last, 1'b0, u16to8_pkg::ERR_NONE);
      endfunction

      function void note_unit(u16to8_pkg::req_type u);
         logic [31:0] w;
         logic [31:0] h;
         w = u.code_unit;
         if (dropping) begin
            if (u.last) dropping = 1'b0;
            return;
         end
         if (mode32) begin
            if (w > u16to8_pkg::SCALAR_MAX ||
                (w >= u16to8_pkg::SURR_FIRST && w <= u16to8_pkg::SURR_LAST))
               reject(u16to8_pkg::ERR_BAD_SCALAR, u.last);
            else
               emit_cp(w[20:0], u.last);
            return;
         end
         // UTF-16: only the low half of the unit counts
         h = {16'h0000, w[15:0]};
         if (hi_pending) begin
            if (h < u16to8_pkg::LOW_FIRST || h > u16to8_pkg::SURR_LAST) begin
               reject(u16to8_pkg::ERR_UNPAIRED_HI, u.last);
            end else begin
               hi_pending = 1'b0;
               emit_cp(u16to8_pkg::SUPP_BASE + {1'b0, held_hi, h[9:0]}, u.last);
               held_hi = '0;
            end
         end else if (h >= u16to8_pkg::SURR_FIRST && h <= u16to8_pkg::HIGH_LAST) begin
            if (u.last) begin
               reject(u16to8_pkg::ERR_UNPAIRED_HI, u.last);
            end else begin
               held_hi = h[9:0];
               hi_pending = 1'b1;
            end
         end else if (h >= u16to8_pkg::LOW_FIRST && h <= u16to8_pkg::SURR_LAST) begin
            reject(u16to8_pkg::ERR_LONE_LO, u.last);
         end else begin
            emit_cp(h[20:0], u.last);
         end
      endfunction

      function void check_byte(u16to8_pkg::rsp_type got);
         u16to8_pkg::rsp_type want;
         if (byte_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: byte %h run %b str %b err %b kind %0d",
                        got.out_byte, got.run_last, got.string_last, got.error,
                        got.error_kind);
            return;
         end
         want = byte_q.pop_front();
         if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
             got.string_last !== want.string_last || got.error !== want.error ||
             got.error_kind !== want.error_kind) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: want %h/%b/%b/%b/%0d got %h/%b/%b/%b/%0d",
                        want.out_byte, want.run_last, want.string_last, want.error,
                        want.error_kind, got.out_byte, got.run_last, got.string_last,
                        got.error, got.error_kind);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   u16to8_pkg::req_type  req_data = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   u16to8_pkg::rsp_type  rsp_data;
   logic                 csr_we = 1'b0;
   logic                 csr_wdata = 1'b0;

   utf8_scoreboard       sb;
   u16to8_pkg::req_type  unit_q[$];
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   quiet_cycles = 0;
   int                   phase_units;
   bit                   moved;

   utf16_to_utf8_transcoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Both channels and the watchdog in one process: inputs are noted before results.
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (csr_we) sb.set_mode(csr_wdata);
         if (req_push && !req_full) begin
            sb.note_unit(req_data);
            moved = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            sb.check_byte(rsp_data);
            moved = 1'b1;
         end
         // hold the word while the queue is full
         if (!(req_push && req_full)) begin
            if (unit_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push <= 1'b1;
               req_data <= unit_q.pop_front();
            end else begin
               req_push <= 1'b0;
               req_data <= {$urandom, 1'($urandom)};
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("utf16_to_utf8_transcoder_core_tb: done, errors");
            $finish;
         end
      end
   end

   task automatic add_unit(input logic [31:0] w, input bit l);
      u16to8_pkg::req_type u;
      u.code_unit = w;
      u.last = l;
      unit_q.insert(unit_q.size(), u);
      phase_units++;
   endtask

   task automatic drain();
      while (unit_q.size() != 0 || req_push) @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      // let units that cause no word leave the pipeline
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] any_scalar();
      case ($urandom_range(3))
         0: return $urandom_range(32'h7F, 32'h0);
         1: return $urandom_range(32'h7FF, 32'h80);
         2: begin
            if ($urandom_range(1) == 0) return $urandom_range(32'hD7FF, 32'h800);
            return $urandom_range(32'hFFFF, 32'hE000);
         end
         default: return $urandom_range(32'h10FFFF, 32'h10000);
      endcase
   endfunction

   // Mostly well-formed strings; a few lone surrogates, bad scalars and raw noise.
   task automatic queue_string(input bit wide32);
      int          len;
      int          pick;
      bit          l;
      logic [31:0] w;
      logic [15:0] top;
      logic [20:0] off;
      len = $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         l = (k == len - 1);
         top = 16'($urandom);
         if (wide32) begin
            if (pick < 88) begin
               w = any_scalar();
            end else if (pick < 94) begin
               w = $urandom_range(u16to8_pkg::SURR_LAST, u16to8_pkg::SURR_FIRST);
            end else begin
               w = $urandom;
               if (w <= u16to8_pkg::SCALAR_MAX) w[31] = 1'b1;
            end
            add_unit(w, l);
         end else if (pick < 85) begin
            w = any_scalar();
            if (w > {11'b0, u16to8_pkg::BMP_MAX}) begin
               off = w[20:0] - u16to8_pkg::SUPP_BASE;
               add_unit({top, 6'b110110, off[19:10]}, 1'b0);
               add_unit({16'($urandom), 6'b110111, off[9:0]}, l);
            end else begin
               add_unit({top, w[15:0]}, l);
            end
         end else if (pick < 90) begin
            add_unit({top, 6'b110111, 10'($urandom)}, l);
         end else if (pick < 95) begin
            add_unit({top, 6'b110110, 10'($urandom)}, l);
         end else begin
            add_unit($urandom, l);
         end
      end
   endtask

   initial begin
      int send_tab[4];
      int recv_tab[4];
      send_tab = '{0, 56, 0, 7};
      recv_tab = '{0, 0, 56, 7};
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // UTF-16 after reset: range edges, pairs and each kind of rejection
      add_unit(32'h0000_0000, 1'b1);
      add_unit(32'h0000_007F, 1'b1);
      add_unit(32'h0000_0080, 1'b0);
      add_unit(32'h0000_07FF, 1'b0);
      add_unit(32'h0000_0800, 1'b0);
      add_unit(32'h0000_FFFF, 1'b1);
      add_unit(32'h0000_D800, 1'b0);
      add_unit(32'h0000_DC00, 1'b1);
      add_unit(32'h0000_DBFF, 1'b0);
      add_unit(32'h0000_DFFF, 1'b1);
      add_unit(32'h0000_D800, 1'b1);
      add_unit(32'h0000_DBFF, 1'b0);
      add_unit(32'h0000_0041, 1'b0);
      add_unit(32'h0000_0043, 1'b1);
      add_unit(32'h0000_DC00, 1'b1);
      add_unit(32'h0000_D900, 1'b0);
      add_unit(32'h0000_DA00, 1'b1);
      add_unit(32'hFFFF_0041, 1'b1);
      drain();

      // a register write drops a held high surrogate and ends dropping
      add_unit(32'h0000_D800, 1'b0);
      drain();
      write_mode(1'b0);
      add_unit(32'h0000_0041, 1'b1);
      add_unit(32'h0000_DC00, 1'b0);
      drain();
      write_mode(1'b1);

      // UTF-32 scalars and invalid values
      add_unit(32'h0000_0000, 1'b0);
      add_unit(32'h0010_FFFF, 1'b0);
      add_unit(32'h0001_0000, 1'b1);
      add_unit(32'h0011_0000, 1'b0);
      add_unit(32'h0000_0041, 1'b1);
      add_unit(32'h0000_D800, 1'b1);
      add_unit(32'hFFFF_FFFF, 1'b1);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_mode(p[0]);
         send_idle_pct = send_tab[p / 2];
         recv_stall_pct = recv_tab[p / 2];
         phase_units = 0;
         while (phase_units < PhaseUnits) queue_string(p[0]);
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("utf16_to_utf8_transcoder_core_tb: done, clean");
      else
         $display("utf16_to_utf8_transcoder_core_tb: done, errors");
      $finish;
   end

endmodule

// ----- utf16_to_utf8_transcoder_core.f -----
rtl/core/u16to8_pkg.sv
rtl/core/u16to8_front.sv
rtl/core/u16to8_fifo.sv
rtl/core/u16to8_back.sv
rtl/core/utf16_to_utf8_transcoder_core.sv
dv/utf16_to_utf8_transcoder_core_tb.sv
